[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks for the step pulse generator; empty when assertions are
// compiled out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
`define STP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define STP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/stp_pkg.sv]
// ----------------------------------------------------------------------------
// stp_pkg
// Shared widths, request codes and types of the trapezoid ramp step pulser.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam int STEP_COUNT_BITS_DEF = 16;
	localparam int HP_W                = 8;
	localparam int POS_W               = 16;
	localparam int MOVE_W              = 16;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_LOAD  = 2'd2;

	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_MIN   = 2'd1;
	localparam logic [1:0] CFG_RAMP  = 2'd2;
	localparam logic [1:0] CFG_EN    = 2'd3;

	typedef struct packed {
		logic [1:0]      phase;
		logic [HP_W-1:0] hp;
	} step_plan_t;

endpackage

[rtl/core/stp_div.sv]
// ----------------------------------------------------------------------------
// stp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stp_div import stp_pkg::*; #(
	parameter int WIDTH = HP_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [WIDTH:0]   rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH:0]   shifted;
	logic             fits;

	assign shifted = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (shifted - {1'b0, divisor}) : shifted;
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/stepper_trapezoid_ramp_pulser.sv]
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_pulser
// Trapezoid-ramp step pulse generator: ticks, move starts, position loads.
// ----------------------------------------------------------------------------
// Timer ticks, position loads and ignored requests take one item per cycle;
// the result sits in an output register, and the next item is taken as soon
// as that register is free or drained. A start move that is accepted while
// the motor is idle runs the ramp increment through the bit-serial divider:
// the accepting edge loads it, the divider produces the eight quotient bits,
// and the edge on which it signals done applies the move plan and registers
// the result; input is stalled until then. The user must see that registers
// are taken only while the block is idle; the block does not enforce this. A
// move latches the ramp settings when its plan is applied.
`include "assert_macros.svh"

module stepper_trapezoid_ramp_pulser import stp_pkg::*; #(
	parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_idx,
	input  logic [HP_W-1:0]          cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic [MOVE_W-1:0]        move_steps,
	input  logic                     move_dir,
	input  logic signed [POS_W-1:0]  new_position,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     step_level,
	output logic                     dir_level,
	output logic                     enable_n,
	output logic signed [POS_W-1:0]  position_now,
	output logic                     busy_res,
	output logic                     move_done
);

	localparam int SC = STEP_COUNT_BITS;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ACCEL = 2'd1;
	localparam logic [1:0] PH_HOLD  = 2'd2;
	localparam logic [1:0] PH_DECEL = 2'd3;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic [HP_W-1:0]  start_hp_q, min_hp_q, ramp_steps_q;
	logic             drv_en_q;

	logic             pin_q, dir_q;
	logic [8:0]       tick_count_q;
	logic [HP_W-1:0]  half_period_q, ramp_delta_q, lat_min_q;
	logic [SC-1:0]    steps_done_q, steps_total_q, accel_end_q, hold_end_q;
	logic [1:0]       phase_q;
	logic [POS_W-1:0] position_q;

	logic             state_q;
	logic [SC-1:0]    n_q;
	logic             mdir_q;

	logic             out_valid_q;
	logic             step_level_q, dir_level_q, enable_n_q, busy_q, done_q;
	logic [POS_W-1:0] position_now_q;

	logic             pin_n, dir_n, done_n;
	logic [8:0]       tick_count_n;
	logic [HP_W-1:0]  half_period_n, ramp_delta_n, lat_min_n;
	logic [SC-1:0]    steps_done_n, steps_total_n, accel_end_n, hold_end_n;
	logic [1:0]       phase_n;
	logic [POS_W-1:0] position_n;

	logic             accept, is_tick, is_load, is_start, apply, out_load;
	logic             div_done;
	logic [HP_W-1:0]  quotient, abs_diff;
	logic             diff_neg;
	logic [31:0]      steps_ext;

	logic [HP_W-1:0]  hp_floor, hp_step;
	logic [8:0]       tick_lim, tick_inc;
	logic [SC-1:0]    steps_inc;
	logic [SC:0]      two_r;
	step_plan_t       plan;

	function automatic step_plan_t enter_step(
		input logic [1:0]      ph,
		input logic [HP_W-1:0] hp,
		input logic [SC-1:0]   sd,
		input logic [SC-1:0]   ae,
		input logic [SC-1:0]   he,
		input logic [HP_W-1:0] mn,
		input logic [HP_W-1:0] delta
	);
		step_plan_t p;
		p.phase = ph;
		p.hp    = hp;
		if (ph == PH_ACCEL && sd >= ae) begin
			if (sd < he) begin
				p.phase = PH_HOLD;
				p.hp    = mn;
			end else begin
				p.phase = PH_DECEL;
				p.hp    = hp + delta;
			end
		end else if (ph == PH_HOLD && sd >= he) begin
			p.phase = PH_DECEL;
		end
		return p;
	endfunction

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign is_tick  = accept && req_type == REQ_TICK;
	assign is_load  = accept && req_type == REQ_LOAD;
	assign is_start = accept && req_type == REQ_START && phase_q == PH_IDLE;
	assign apply    = state_q == ST_DIV && div_done;
	assign out_load = (accept && !is_start) || apply;

	assign diff_neg  = start_hp_q < min_hp_q;
	assign abs_diff  = diff_neg ? (min_hp_q - start_hp_q) : (start_hp_q - min_hp_q);
	assign steps_ext = 32'(move_steps);

	stp_div #(
		.WIDTH (HP_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (is_start),
		.dividend (abs_diff),
		.divisor  (ramp_steps_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign hp_floor  = (half_period_q > HP_W'(1)) ? half_period_q : HP_W'(1);
	assign tick_lim  = {1'b0, hp_floor} + 9'd1;
	assign tick_inc  = tick_count_q + 9'd1;
	assign steps_inc = steps_done_q + SC'(1);
	assign two_r     = (SC + 1)'({ramp_steps_q, 1'b0});

	always_comb begin
		pin_n         = pin_q;
		dir_n         = dir_q;
		done_n        = 1'b0;
		tick_count_n  = tick_count_q;
		half_period_n = half_period_q;
		ramp_delta_n  = ramp_delta_q;
		lat_min_n     = min_hp_q;
		steps_done_n  = steps_done_q;
		steps_total_n = steps_total_q;
		accel_end_n   = accel_end_q;
		hold_end_n    = hold_end_q;
		phase_n       = phase_q;
		position_n    = position_q;
		hp_step       = half_period_q;
		plan          = '0;
		if (apply) begin
			ramp_delta_n  = (ramp_steps_q == '0) ? '0 :
				(diff_neg ? (HP_W'(0) - quotient) : quotient);
			dir_n         = mdir_q;
			steps_total_n = n_q;
			steps_done_n  = '0;
			tick_count_n  = '0;
			half_period_n = start_hp_q;
			if (n_q == '0) begin
				phase_n = PH_IDLE;
				done_n  = 1'b1;
			end else begin
				if ({1'b0, n_q} > two_r) begin
					accel_end_n = SC'(ramp_steps_q);
					hold_end_n  = n_q - SC'(ramp_steps_q);
				end else begin
					accel_end_n = n_q >> 1;
					hold_end_n  = n_q >> 1;
				end
				plan = enter_step(PH_ACCEL, start_hp_q, '0, accel_end_n, hold_end_n,
					min_hp_q, ramp_delta_n);
				phase_n       = plan.phase;
				half_period_n = plan.hp;
			end
		end else if (is_load) begin
			position_n = new_position;
		end else if (is_tick && phase_q != PH_IDLE) begin
			if (tick_inc < tick_lim) begin
				tick_count_n = tick_inc;
			end else begin
				tick_count_n = '0;
				pin_n        = ~pin_q;
				if (!pin_q) begin
					position_n = dir_q ? (position_q + POS_W'(1)) : (position_q - POS_W'(1));
					if (phase_q == PH_ACCEL) begin
						hp_step = half_period_q - ramp_delta_q;
					end else if (phase_q == PH_DECEL) begin
						hp_step = half_period_q + ramp_delta_q;
					end
					steps_done_n  = steps_inc;
					half_period_n = hp_step;
					if (steps_inc == steps_total_q) begin
						phase_n = PH_IDLE;
						done_n  = 1'b1;
					end else begin
						plan = enter_step(phase_q, hp_step, steps_inc, accel_end_q,
							hold_end_q, lat_min_q, ramp_delta_q);
						phase_n       = plan.phase;
						half_period_n = plan.hp;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hp_q   <= 8'd255;
			min_hp_q     <= 8'd255;
			ramp_steps_q <= 8'd1;
			drv_en_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_START: start_hp_q   <= cfg_wdata;
				CFG_MIN:   min_hp_q     <= cfg_wdata;
				CFG_RAMP:  ramp_steps_q <= cfg_wdata;
				CFG_EN:    drv_en_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q         <= 1'b0;
			dir_q         <= 1'b0;
			tick_count_q  <= '0;
			half_period_q <= '0;
			ramp_delta_q  <= '0;
			lat_min_q     <= '0;
			steps_done_q  <= '0;
			steps_total_q <= '0;
			accel_end_q   <= '0;
			hold_end_q    <= '0;
			phase_q       <= PH_IDLE;
			position_q    <= '0;
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
		end else begin
			pin_q         <= pin_n;
			dir_q         <= dir_n;
			tick_count_q  <= tick_count_n;
			half_period_q <= half_period_n;
			ramp_delta_q  <= ramp_delta_n;
			steps_done_q  <= steps_done_n;
			steps_total_q <= steps_total_n;
			accel_end_q   <= accel_end_n;
			hold_end_q    <= hold_end_n;
			phase_q       <= phase_n;
			position_q    <= position_n;
			if (apply) begin
				lat_min_q <= lat_min_n;
			end
			unique case (state_q)
				ST_IDLE: if (is_start) state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_start) begin
			n_q    <= steps_ext[SC-1:0];
			mdir_q <= move_dir;
		end
		if (out_load) begin
			step_level_q   <= pin_n;
			dir_level_q    <= dir_n;
			enable_n_q     <= ~drv_en_q;
			position_now_q <= position_n;
			busy_q         <= phase_n != PH_IDLE;
			done_q         <= done_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign step_level   = step_level_q;
	assign dir_level    = dir_level_q;
	assign enable_n     = enable_n_q;
	assign position_now = position_now_q;
	assign busy_res     = busy_q;
	assign move_done    = done_q;

	`STP_ASSERT_IMP(a_stall_while_div, clk, arst_n, state_q == ST_DIV, in_stall)
	`STP_ASSERT_NXT(a_result_after_div, clk, arst_n, apply, out_valid_q)
	`STP_ASSERT_IMP(a_done_not_busy, clk, arst_n, out_valid_q, !(done_q && busy_q))
	`STP_ASSERT_IMP(a_idle_count_clear, clk, arst_n, phase_q == PH_IDLE, tick_count_q == '0)

endmodule

[tb/tb_stepper_trapezoid_ramp_pulser.sv]
// ----------------------------------------------------------------------------
// tb_stepper_trapezoid_ramp_pulser
// Self-checking bench for the trapezoid-ramp step pulse generator. Directed
// tests cover idle requests, register extremes, wrapping ramps and positions,
// pyramid moves and requests that arrive mid-move. A random phase follows
// with short moves under many settings. A bit-exact model of the
// half-period schedule predicts every result, and each result is checked
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_stepper_trapezoid_ramp_pulser import stp_pkg::*; ();

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 60;
	localparam int RANDOM_ITEMS  = 250;

	typedef enum logic [1:0] {MV_IDLE, MV_ACCEL, MV_HOLD, MV_DECEL} move_phase_t;

	typedef struct {
		logic               step;
		logic               dir;
		logic               en_n;
		logic signed [15:0] pos;
		logic               busy;
		logic               done;
	} pulse_out_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [1:0]               cfg_idx;
	logic [HP_W-1:0]          cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               req_type;
	logic [MOVE_W-1:0]        move_steps;
	logic                     move_dir;
	logic signed [POS_W-1:0]  new_position;
	logic                     out_valid;
	logic                     out_stall;
	logic                     step_level;
	logic                     dir_level;
	logic                     enable_n;
	logic signed [POS_W-1:0]  position_now;
	logic                     busy_res;
	logic                     move_done;

	stepper_trapezoid_ramp_pulser uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .move_steps(move_steps), .move_dir(move_dir),
		.new_position(new_position),
		.out_valid(out_valid), .out_stall(out_stall),
		.step_level(step_level), .dir_level(dir_level), .enable_n(enable_n),
		.position_now(position_now), .busy_res(busy_res), .move_done(move_done)
	);

	// settings copy and ramp state
	logic [7:0]  set_start, set_min, set_ramp;
	logic        set_enable;
	logic        pin_q, dir_q;
	logic [8:0]  tick_q;
	logic [7:0]  hp_q, delta_q, lat_min_q;
	logic [15:0] done_q, total_q;
	logic [15:0] pos_q;
	move_phase_t phase_q;
	int          accel_end_q, hold_end_q;

	pulse_out_t  pulse_outs_due[$];
	int          errors;
	int          items_sent;
	int          results_checked;
	int          moves_finished;
	int          quiet_cycles;
	bit          tx_idle_on;
	bit          rx_idle_on;
	bit          hold_request;
	int          hold_left;

	always #5 clk = ~clk;

	function automatic void pick_segment();
		if (phase_q == MV_ACCEL && done_q >= accel_end_q) begin
			if (done_q < hold_end_q) begin
				phase_q = MV_HOLD;
				hp_q = lat_min_q;
			end else begin
				phase_q = MV_DECEL;
				hp_q = hp_q + delta_q;
			end
		end else if (phase_q == MV_HOLD && done_q >= hold_end_q) begin
			phase_q = MV_DECEL;
		end
	endfunction

	function automatic void plan_move(logic [15:0] n, logic dir);
		int diff;
		int quot;
		int r;
		int cnt;
		r = set_ramp;
		cnt = n;
		diff = int'(set_start) - int'(set_min);
		quot = 0;
		if (r != 0)
			quot = diff / r;
		delta_q = quot[7:0];
		lat_min_q = set_min;
		dir_q = dir;
		total_q = n;
		done_q = '0;
		tick_q = '0;
		hp_q = set_start;
		if (cnt == 0) begin
			phase_q = MV_IDLE;
			return;
		end
		if (cnt > 2 * r) begin
			accel_end_q = r;
			hold_end_q = cnt - r;
		end else begin
			accel_end_q = cnt >> 1;
			hold_end_q = cnt >> 1;
		end
		phase_q = MV_ACCEL;
		pick_segment();
	endfunction

	function automatic logic advance_tick();
		int lim;
		if (phase_q == MV_IDLE)
			return 1'b0;
		lim = ((hp_q > 8'd1) ? int'(hp_q) : 1) + 1;
		tick_q = tick_q + 9'd1;
		if (int'(tick_q) < lim)
			return 1'b0;
		tick_q = '0;
		pin_q = ~pin_q;
		if (!pin_q)
			return 1'b0;
		pos_q = dir_q ? pos_q + 16'd1 : pos_q - 16'd1;
		if (phase_q == MV_ACCEL)
			hp_q = hp_q - delta_q;
		else if (phase_q == MV_DECEL)
			hp_q = hp_q + delta_q;
		done_q = done_q + 16'd1;
		if (done_q == total_q) begin
			phase_q = MV_IDLE;
			return 1'b1;
		end
		pick_segment();
		return 1'b0;
	endfunction

	function automatic void predict_pulse_outputs(logic [1:0] req, logic [15:0] n, logic dir,
			logic signed [15:0] pos);
		pulse_out_t r;
		logic fin;
		fin = 1'b0;
		case (req)
			REQ_TICK: fin = advance_tick();
			REQ_START: if (phase_q == MV_IDLE) begin
				plan_move(n, dir);
				fin = (phase_q == MV_IDLE);
			end
			REQ_LOAD: pos_q = pos;
			default: ;
		endcase
		r.step = pin_q;
		r.dir = dir_q;
		r.en_n = ~set_enable;
		r.pos = pos_q;
		r.busy = (phase_q != MV_IDLE);
		r.done = fin;
		if (fin)
			moves_finished++;
		pulse_outs_due.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	task automatic send_item(input logic [1:0] req, input logic [15:0] n, input logic dir,
			input logic signed [15:0] pos);
		if (tx_idle_on) begin
			while ($urandom_range(0, 99) < 33) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= req;
		move_steps <= n;
		move_dir <= dir;
		new_position <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		predict_pulse_outputs(req, n, dir, pos);
	endtask

	task automatic send_tick();
		send_item(REQ_TICK, 16'($urandom), 1'($urandom), 16'($urandom));
	endtask

	task automatic ticks_until_stopped();
		while (phase_q != MV_IDLE)
			send_tick();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pulse_outs_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_START: set_start = val;
			CFG_MIN: set_min = val;
			CFG_RAMP: set_ramp = val;
			CFG_EN: set_enable = val[0];
		endcase
	endtask

	task automatic write_ramp(input logic [7:0] st, input logic [7:0] mn, input logic [7:0] rs);
		write_reg(CFG_START, st);
		write_reg(CFG_MIN, mn);
		write_reg(CFG_RAMP, rs);
	endtask

	task automatic test_idle_requests();
		send_tick();
		send_item(REQ_UNUSED, 16'hFFFF, 1'b1, 16'sh7FFF);
		send_item(REQ_LOAD, 16'h0000, 1'b0, 16'sh7FFF);
		send_item(REQ_LOAD, 16'hFFFF, 1'b1, -16'sh8000);
		send_item(REQ_START, 16'h0000, 1'b1, 16'sh0000);
		send_item(REQ_START, 16'h0000, 1'b0, -16'sh0001);
		send_item(REQ_LOAD, 16'h0000, 1'b0, 16'sh0000);
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_EN, 8'd1);
		write_ramp(8'd255, 8'd0, 8'd0);
		send_item(REQ_START, 16'd1, 1'b1, 16'sh0);
		ticks_until_stopped();
		write_ramp(8'd0, 8'd255, 8'd255);
		send_item(REQ_START, 16'd2, 1'b0, 16'sh0);
		ticks_until_stopped();
		write_reg(CFG_EN, 8'd0);
	endtask

	task automatic test_wrapping_moves();
		write_ramp(8'd2, 8'd5, 8'd2);
		send_item(REQ_LOAD, 16'd0, 1'b0, -16'sh8000);
		send_item(REQ_START, 16'd6, 1'b0, 16'sh0);
		ticks_until_stopped();
		write_ramp(8'd4, 8'd1, 8'd3);
		send_item(REQ_LOAD, 16'd0, 1'b0, 16'sh7FFF);
		send_item(REQ_START, 16'd1, 1'b1, 16'sh0);
		ticks_until_stopped();
		write_ramp(8'd1, 8'd3, 8'd1);
		send_item(REQ_START, 16'd3, 1'b1, 16'sh0);
		ticks_until_stopped();
	endtask

	task automatic test_requests_mid_move();
		write_ramp(8'd3, 8'd1, 8'd1);
		send_item(REQ_START, 16'd4, 1'b1, 16'sh0);
		repeat (5) send_tick();
		send_item(REQ_START, 16'hFFFF, 1'b0, 16'sh0);
		send_item(REQ_LOAD, 16'd0, 1'b0, 16'sh1234);
		write_reg(CFG_START, 8'd6);
		ticks_until_stopped();
		send_item(REQ_START, 16'd3, 1'b0, 16'sh0);
		ticks_until_stopped();
	endtask

	task automatic test_output_backpressure();
		write_ramp(8'd2, 8'd0, 8'd2);
		send_item(REQ_START, 16'd5, 1'b1, 16'sh0);
		tx_idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (30) send_tick();
		tx_idle_on = 1'b1;
		ticks_until_stopped();
	endtask

	task automatic test_random_moves();
		int counted;
		int pick;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			tx_idle_on = !(counted > RANDOM_ITEMS / 3 && counted < RANDOM_ITEMS / 2);
			rx_idle_on = tx_idle_on;
			if ($urandom_range(0, 2) == 0) begin
				write_ramp(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
					8'($urandom_range(0, 5)));
				write_reg(CFG_EN, 8'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 4) == 0) begin
				send_item(REQ_LOAD, 16'($urandom), 1'($urandom), 16'($urandom));
				counted++;
			end
			send_item(REQ_START, 16'($urandom_range(0, 5)), 1'($urandom), 16'($urandom));
			counted++;
			while (phase_q != MV_IDLE) begin
				pick = $urandom_range(0, 29);
				if (pick == 0) begin
					send_item(REQ_LOAD, 16'($urandom), 1'($urandom), 16'($urandom));
					counted++;
				end else if (pick == 1) begin
					send_item(REQ_START, 16'($urandom), 1'($urandom), 16'($urandom));
				end else if (pick == 2) begin
					send_item(REQ_UNUSED, 16'($urandom), 1'($urandom), 16'($urandom));
				end else begin
					send_tick();
					counted++;
				end
			end
			if ($urandom_range(0, 3) == 0)
				send_tick();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_longest_move();
		write_ramp(8'd0, 8'd0, 8'd0);
		send_item(REQ_START, 16'hFFFF, 1'b1, 16'sh0);
		repeat (40) send_tick();
		send_item(REQ_LOAD, 16'd0, 1'b0, -16'sh0002);
		repeat (20) send_tick();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= rx_idle_on && ($urandom_range(0, 99) < 33);
		end
	end

	always @(posedge clk) begin
		pulse_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pulse_outs_due.size() == 0) begin
				$display("[%0t] result arrived with nothing expected", $time);
				errors++;
			end else begin
				want = pulse_outs_due.pop_front();
				if (step_level !== want.step)
					report_mismatch("step_level", want.step, step_level);
				if (dir_level !== want.dir)
					report_mismatch("dir_level", want.dir, dir_level);
				if (enable_n !== want.en_n)
					report_mismatch("enable_n", want.en_n, enable_n);
				if (position_now !== want.pos)
					report_mismatch("position_now", want.pos, position_now);
				if (busy_res !== want.busy)
					report_mismatch("busy_res", want.busy, busy_res);
				if (move_done !== want.done)
					report_mismatch("move_done", want.done, move_done);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		req_type <= REQ_TICK;
		move_steps <= '0;
		move_dir <= 1'b0;
		new_position <= '0;
		set_start = 8'd255;
		set_min = 8'd255;
		set_ramp = 8'd1;
		set_enable = 1'b0;
		pin_q = 1'b0;
		dir_q = 1'b0;
		tick_q = '0;
		hp_q = '0;
		delta_q = '0;
		lat_min_q = '0;
		done_q = '0;
		total_q = '0;
		pos_q = '0;
		phase_q = MV_IDLE;
		accel_end_q = 0;
		hold_end_q = 0;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		moves_finished = 0;
		quiet_cycles = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_request = 1'b0;
		hold_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_requests();
		test_register_extremes();
		test_wrapping_moves();
		test_requests_mid_move();
		test_output_backpressure();
		test_random_moves();
		test_longest_move();
		in_valid <= 1'b0;
		while (pulse_outs_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d items and %0d finished moves; %0d results compared, %0d mismatches",
			items_sent, moves_finished, results_checked, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/stp_pkg.sv
rtl/core/stp_div.sv
rtl/core/stepper_trapezoid_ramp_pulser.sv
tb/tb_stepper_trapezoid_ramp_pulser.sv
